// ===== rtl/core/tfr_pkg.sv =====
// Triangle tangent frame: shared widths, job record, state encodings and helpers.
// Depends on nothing; every other file of the block imports it.
package tfr_pkg;

    localparam int POS_W   = 24;
    localparam int TEX_W   = 16;
    localparam int UNIT_W  = 16;
    localparam int FRAC_W  = UNIT_W - 2;

    // Edge and UV delta widths, one extra bit for the difference.
    localparam int E_W     = POS_W + 1;
    localparam int D_W     = TEX_W + 1;
    localparam int OP_W    = (E_W > D_W) ? E_W : D_W;
    localparam int PROD_W  = 2 * OP_W;
    localparam int MAG_W   = PROD_W + 1;
    localparam int SHRINK  = (POS_W > 30) ? (POS_W - 30) : 0;

    // Normalizer: magnitudes are aligned so the largest has its top bit at NORM_MSB.
    localparam int NORM_MSB   = 29;
    localparam int SQ_W       = 2 * (NORM_MSB + 1);
    localparam int RAD_W      = SQ_W + 2;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int ROOT_W     = NORM_MSB + 2;
    localparam int QUO_W      = FRAC_W + 2;
    localparam int DIV_W      = ROOT_W + QUO_W;
    localparam int CNT_W      = $clog2(ROOT_STEPS + 1);

    // Product sequence: ten two-term differences.
    localparam int N_RES     = 10;
    localparam int MUL_STEPS = 2 * N_RES;
    localparam int STEP_W    = $clog2(MUL_STEPS + 1);
    localparam int RES_IDX_W = $clog2(N_RES);

    // Stream layout.
    localparam int OFF_PY  = POS_W;
    localparam int OFF_PZ  = 2 * POS_W;
    localparam int OFF_U   = 3 * POS_W;
    localparam int OFF_V   = OFF_U + TEX_W;
    localparam int OFF_N   = OFF_V + TEX_W;
    localparam int IN_W    = OFF_N + 3 * UNIT_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = 9 * UNIT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int OFF_TAN = 3 * UNIT_W;

    localparam int FIFO_DEPTH = 2;

    // Corner codes.
    localparam logic [1:0] CORNER_0    = 2'd0;
    localparam logic [1:0] CORNER_1    = 2'd1;
    localparam logic [1:0] CORNER_LAST = 2'd2;
    localparam logic [1:0] CORNER_NONE = 2'd3;

    // Register index.
    localparam logic [0:0] REG_RENORM = 1'd0;

    typedef struct packed {
        logic [2:0][E_W-1:0]    e1;
        logic [2:0][E_W-1:0]    e2;
        logic [D_W-1:0]         d1u;
        logic [D_W-1:0]         d1v;
        logic [D_W-1:0]         d2u;
        logic [D_W-1:0]         d2v;
        logic [2:0][2:0][UNIT_W-1:0] n;   // [corner][axis]
    } t_job;

    typedef enum logic [2:0] {
        BS_IDLE, BS_MUL, BS_NSTART, BS_NWAIT, BS_EMIT
    } t_bstate;

    typedef enum logic [2:0] {
        US_IDLE, US_SHIFT, US_SQUARE, US_ROOT, US_DLOAD, US_DIV, US_DONE
    } t_ustate;

    function automatic logic signed [E_W-1:0] shrink_edge(input logic signed [E_W-1:0] e);
        logic [E_W-1:0] mag;
        mag = e[E_W-1] ? E_W'(-e) : E_W'(e);
        mag = mag >> SHRINK;
        return e[E_W-1] ? $signed(-mag) : $signed(mag);
    endfunction

endpackage

// ===== rtl/core/tfr_unitize.sv =====
// Iterative vector normalizer: align, sum of squares, bit-serial root, serial divide.
// Depends on tfr_pkg.
module tfr_unitize
    import tfr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [2:0][MAG_W-1:0]       i_mag,
    output logic                        o_done,
    output logic [2:0][QUO_W-1:0]       o_q
);

    t_ustate r_state, n_state;
    logic [MAG_W-1:0]  r_m [3];
    logic [MAG_W-1:0]  r_top;
    logic [CNT_W-1:0]  r_cnt;
    logic [SQ_W-1:0]   r_sq;
    logic [RAD_W-1:0]  r_sum, r_x, r_root, r_bit;
    logic [1:0]        r_j;
    logic [DIV_W-1:0]  r_num, r_dsub;
    logic [QUO_W-1:0]  r_q [3];

    logic [MAG_W-1:0]  w_max;
    logic              w_high, w_aligned;
    logic [RAD_W-1:0]  w_trial;
    logic [NORM_MSB:0] w_sq_op;
    logic [DIV_W-1:0]  w_num0;

    always_comb begin
        w_max = i_mag[0];
        if (i_mag[1] > w_max) w_max = i_mag[1];
        if (i_mag[2] > w_max) w_max = i_mag[2];
    end

    assign w_high    = |r_top[MAG_W-1:NORM_MSB+1];
    assign w_aligned = !w_high && r_top[NORM_MSB];
    assign w_trial   = r_root + r_bit;
    assign w_sq_op   = (r_cnt[1:0] == 2'd0) ? r_m[0][NORM_MSB:0] :
                       (r_cnt[1:0] == 2'd1) ? r_m[1][NORM_MSB:0] : r_m[2][NORM_MSB:0];
    assign w_num0    = DIV_W'({r_m[r_j][NORM_MSB:0], {FRAC_W{1'b0}}})
                     + DIV_W'(r_root[ROOT_W-1:1]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            US_IDLE:   if (i_start) n_state = (w_max == '0) ? US_DONE : US_SHIFT;
            US_SHIFT:  if (w_aligned) n_state = US_SQUARE;
            US_SQUARE: if (r_cnt == CNT_W'(3)) n_state = US_ROOT;
            US_ROOT:   if (r_cnt == CNT_W'(ROOT_STEPS - 1)) n_state = US_DLOAD;
            US_DLOAD:  n_state = US_DIV;
            US_DIV: begin
                if (r_cnt == CNT_W'(QUO_W - 1)) n_state = (r_j == 2'd2) ? US_DONE : US_DLOAD;
            end
            US_DONE:   n_state = US_IDLE;
            default:   n_state = US_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == US_DONE);
        for (int i = 0; i < 3; i++) o_q[i] = r_q[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= US_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            US_IDLE: begin
                if (i_start) begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= i_mag[i];
                        r_q[i] <= '0;
                    end
                    r_top <= w_max;
                    r_cnt <= '0;
                    r_sum <= '0;
                    r_j   <= '0;
                end
            end
            US_SHIFT: begin
                // one bit per cycle; repeated truncating right shifts equal one big shift
                if (w_high) begin
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    r_top <= r_top >> 1;
                end else if (!r_top[NORM_MSB]) begin
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    r_top <= r_top << 1;
                end
            end
            US_SQUARE: begin
                if (r_cnt != CNT_W'(3)) begin
                    r_sq  <= SQ_W'(w_sq_op) * SQ_W'(w_sq_op);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt != '0) r_sum <= r_sum + RAD_W'(r_sq);
                end else begin
                    r_x    <= r_sum + RAD_W'(r_sq);
                    r_root <= '0;
                    r_bit  <= RAD_W'(1) << (RAD_W - 2);
                    r_cnt  <= '0;
                end
            end
            US_ROOT: begin
                if (r_x >= w_trial) begin
                    r_x    <= r_x - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= (r_cnt == CNT_W'(ROOT_STEPS - 1)) ? '0 : r_cnt + 1'b1;
            end
            US_DLOAD: begin
                r_num  <= w_num0;
                r_dsub <= DIV_W'(r_root[ROOT_W-1:0]) << (QUO_W - 1);
                r_cnt  <= '0;
            end
            US_DIV: begin
                if (r_num >= r_dsub) r_num <= r_num - r_dsub;
                r_q[r_j] <= {r_q[r_j][QUO_W-2:0], (r_num >= r_dsub)};
                r_dsub   <= r_dsub >> 1;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) r_j <= r_j + 1'b1;
            end
            US_DONE: ;
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/tfr_front.sv =====
// Front end: takes corner requests, holds corners 0 and 1, forms one job per corner 2.
// Depends on tfr_pkg.
module tfr_front
    import tfr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_corner,
    input  logic [IN_TDATA_W-1:0]  i_data,
    input  logic                   i_full,
    output logic                   o_push,
    output t_job                   o_job
);

    logic signed [POS_W-1:0] r_pos [2][3];
    logic signed [TEX_W-1:0] r_tex [2][2];
    logic [UNIT_W-1:0]       r_nrm [2][3];

    logic signed [POS_W-1:0] w_p [3];
    logic signed [TEX_W-1:0] w_t [2];
    logic [UNIT_W-1:0]       w_n [3];
    logic                    w_acc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_p[i] = $signed(i_data[i*POS_W +: POS_W]);
            w_n[i] = i_data[OFF_N + i*UNIT_W +: UNIT_W];
        end
        w_t[0] = $signed(i_data[OFF_U +: TEX_W]);
        w_t[1] = $signed(i_data[OFF_V +: TEX_W]);
    end

    assign o_ready = !i_full;
    assign w_acc   = i_valid && o_ready;
    assign o_push  = w_acc && (i_corner == CORNER_LAST);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_job.e1[i] = E_W'(E_W'(r_pos[1][i]) - E_W'(r_pos[0][i]));
            o_job.e2[i] = E_W'(E_W'(w_p[i]) - E_W'(r_pos[0][i]));
            o_job.n[0][i] = r_nrm[0][i];
            o_job.n[1][i] = r_nrm[1][i];
            o_job.n[2][i] = w_n[i];
        end
        o_job.d1u = D_W'(D_W'(r_tex[1][0]) - D_W'(r_tex[0][0]));
        o_job.d1v = D_W'(D_W'(r_tex[1][1]) - D_W'(r_tex[0][1]));
        o_job.d2u = D_W'(D_W'(w_t[0]) - D_W'(r_tex[0][0]));
        o_job.d2v = D_W'(D_W'(w_t[1]) - D_W'(r_tex[0][1]));
    end

    // corners 0 and 1 just overwrite their slot; the unused code is dropped
    always_ff @(posedge i_clk) begin
        if (w_acc && (i_corner == CORNER_0 || i_corner == CORNER_1)) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i_corner[0]][i] <= w_p[i];
                r_nrm[i_corner[0]][i] <= w_n[i];
            end
            r_tex[i_corner[0]][0] <= w_t[0];
            r_tex[i_corner[0]][1] <= w_t[1];
        end
    end

endmodule

// ===== rtl/core/tfr_fifo.sv =====
// Short job queue between front and back end.
// Depends on tfr_pkg.
module tfr_fifo
    import tfr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_job,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_job  o_job
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_job               r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [PTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

endmodule

// ===== rtl/core/tfr_back.sv =====
// Back end: shared multiplier sequence, up to three normalizations, three result requests.
// Depends on tfr_pkg and tfr_unitize.
module tfr_back
    import tfr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_renorm,
    input  logic                    i_empty,
    input  t_job                    i_job,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [OUT_TDATA_W-1:0]  o_data,
    output logic [2:0]              o_user,
    output logic                    o_last
);

    t_bstate r_state, n_state;
    t_job    r_job;
    logic [STEP_W-1:0]          r_s, r_pidx;
    logic                       r_pv;
    logic signed [PROD_W-1:0]   r_prod, r_acc;
    logic signed [MAG_W-1:0]    r_res [N_RES];
    logic [1:0]                 r_vec, r_k;
    logic [2:0][UNIT_W-1:0]     r_ut, r_ub, r_fn;

    logic signed [D_W-1:0]  w_d1u, w_d1v, w_d2u, w_d2v;
    logic signed [E_W-1:0]  w_e1 [3], w_e2 [3], w_a [3], w_b [3];
    logic signed [OP_W-1:0] w_opa, w_opb;
    logic                   w_issue, w_det_neg, w_valid, w_need;
    logic signed [MAG_W-1:0] w_vec [3];
    logic [2:0][MAG_W-1:0]  w_mag;
    logic                   w_udone, w_ustart;
    logic [2:0][QUO_W-1:0]  w_q;
    logic [2:0][UNIT_W-1:0] w_signed_q;

    always_comb begin
        w_d1u = $signed(r_job.d1u);
        w_d1v = $signed(r_job.d1v);
        w_d2u = $signed(r_job.d2u);
        w_d2v = $signed(r_job.d2v);
        for (int i = 0; i < 3; i++) begin
            w_e1[i] = $signed(r_job.e1[i]);
            w_e2[i] = $signed(r_job.e2[i]);
            w_a[i]  = shrink_edge(w_e1[i]);
            w_b[i]  = shrink_edge(w_e2[i]);
        end
    end

    // operand schedule: even step is the first term, odd step the subtracted term
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        unique case (r_s)
            5'd0:  begin w_opa = OP_W'(w_d1u);   w_opb = OP_W'(w_d2v);   end
            5'd1:  begin w_opa = OP_W'(w_d2u);   w_opb = OP_W'(w_d1v);   end
            5'd2:  begin w_opa = OP_W'(w_d2v);   w_opb = OP_W'(w_e1[0]); end
            5'd3:  begin w_opa = OP_W'(w_d1v);   w_opb = OP_W'(w_e2[0]); end
            5'd4:  begin w_opa = OP_W'(w_d2v);   w_opb = OP_W'(w_e1[1]); end
            5'd5:  begin w_opa = OP_W'(w_d1v);   w_opb = OP_W'(w_e2[1]); end
            5'd6:  begin w_opa = OP_W'(w_d2v);   w_opb = OP_W'(w_e1[2]); end
            5'd7:  begin w_opa = OP_W'(w_d1v);   w_opb = OP_W'(w_e2[2]); end
            5'd8:  begin w_opa = OP_W'(w_d1u);   w_opb = OP_W'(w_e2[0]); end
            5'd9:  begin w_opa = OP_W'(w_d2u);   w_opb = OP_W'(w_e1[0]); end
            5'd10: begin w_opa = OP_W'(w_d1u);   w_opb = OP_W'(w_e2[1]); end
            5'd11: begin w_opa = OP_W'(w_d2u);   w_opb = OP_W'(w_e1[1]); end
            5'd12: begin w_opa = OP_W'(w_d1u);   w_opb = OP_W'(w_e2[2]); end
            5'd13: begin w_opa = OP_W'(w_d2u);   w_opb = OP_W'(w_e1[2]); end
            5'd14: begin w_opa = OP_W'(w_a[1]);  w_opb = OP_W'(w_b[2]);  end
            5'd15: begin w_opa = OP_W'(w_a[2]);  w_opb = OP_W'(w_b[1]);  end
            5'd16: begin w_opa = OP_W'(w_a[2]);  w_opb = OP_W'(w_b[0]);  end
            5'd17: begin w_opa = OP_W'(w_a[0]);  w_opb = OP_W'(w_b[2]);  end
            5'd18: begin w_opa = OP_W'(w_a[0]);  w_opb = OP_W'(w_b[1]);  end
            5'd19: begin w_opa = OP_W'(w_a[1]);  w_opb = OP_W'(w_b[0]);  end
            default: ;
        endcase
    end

    assign w_issue   = (r_state == BS_MUL) && (r_s != STEP_W'(MUL_STEPS));
    assign w_det_neg = r_res[0][MAG_W-1];
    assign w_valid   = (r_res[0] != '0);
    assign w_need    = (r_vec == 2'd2) || w_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_vec[i] = (r_vec == 2'd0) ? r_res[1+i] :
                       (r_vec == 2'd1) ? r_res[4+i] : r_res[7+i];
            w_mag[i] = w_vec[i][MAG_W-1] ? MAG_W'(-w_vec[i]) : MAG_W'(w_vec[i]);
            // det sign flips tangent and bitangent only
            w_signed_q[i] = (w_vec[i][MAG_W-1] ^ (w_det_neg && (r_vec != 2'd2)))
                          ? UNIT_W'(-UNIT_W'(w_q[i])) : UNIT_W'(w_q[i]);
        end
    end

    assign w_ustart = (r_state == BS_NSTART) && w_need;

    tfr_unitize u_unitize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ustart),
        .i_mag   (w_mag),
        .o_done  (w_udone),
        .o_q     (w_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE:   if (!i_empty) n_state = BS_MUL;
            BS_MUL:    if (r_pv && r_pidx == STEP_W'(MUL_STEPS - 1)) n_state = BS_NSTART;
            BS_NSTART: begin
                if (w_need)               n_state = BS_NWAIT;
                else if (r_vec == 2'd2)   n_state = BS_EMIT;
            end
            BS_NWAIT:  if (w_udone) n_state = (r_vec == 2'd2) ? BS_EMIT : BS_NSTART;
            BS_EMIT:   if (i_ready && r_k == CORNER_LAST) n_state = BS_IDLE;
            default:   n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = (r_state == BS_IDLE) && !i_empty;
        o_valid = (r_state == BS_EMIT);
        o_last  = (r_k == CORNER_LAST);
        o_user  = {w_valid, r_k};
        o_data  = '0;
        for (int i = 0; i < 3; i++) begin
            o_data[i*UNIT_W +: UNIT_W] = i_renorm ? r_fn[i] : r_job.n[r_k][i];
            o_data[OFF_TAN + i*UNIT_W +: UNIT_W]            = r_ut[i];
            o_data[OFF_TAN + (3+i)*UNIT_W +: UNIT_W]        = r_ub[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_s     <= '0;
            r_pv    <= 1'b0;
            r_vec   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= w_issue;
            if (w_issue) r_s <= r_s + 1'b1;
            unique case (r_state)
                BS_IDLE: begin
                    r_s   <= '0;
                    r_vec <= '0;
                    r_k   <= CORNER_0;
                end
                BS_NSTART: if (!w_need) r_vec <= r_vec + 1'b1;
                BS_NWAIT:  if (w_udone) r_vec <= r_vec + 1'b1;
                BS_EMIT:   if (i_ready) r_k <= r_k + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_ut  <= '0;
            r_ub  <= '0;
        end
        r_pidx <= r_s;
        if (w_issue) r_prod <= w_opa * w_opb;
        if (r_pv) begin
            if (!r_pidx[0]) r_acc <= r_prod;
            else r_res[r_pidx[RES_IDX_W:1]] <= MAG_W'(r_acc) - MAG_W'(r_prod);
        end
        if (r_state == BS_NWAIT && w_udone) begin
            unique case (r_vec)
                2'd0:    r_ut <= w_signed_q;
                2'd1:    r_ub <= w_signed_q;
                default: r_fn <= w_signed_q;
            endcase
        end
    end

endmodule

// ===== rtl/core/triangle_tangent_frame_core.sv =====
// From the corner 2 request to the first result, a job passes the queue, the product
//   sequence and, per normalized vector, align (up to 29 bits), square, root and divide.
// Throughput: one triangle per back-end pass (three results, one per cycle when taken);
//   corners 0 and 1 go in one per cycle unless the queue is full; it holds two jobs.
// Reset (synchronous, active low) empties the queue, idles both ends and clears the
//   renormalize register; held corners stay undefined until written.
module triangle_tangent_frame_core
    import tfr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata: position_x, position_y, position_z, tex_u, tex_v,
    //        in_normal_x, in_normal_y, in_normal_z (lowest first)
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: corner
    input  logic [1:0]              s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tdata: normal_x/y/z, tangent_x/y/z, bitangent_x/y/z (lowest first)
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    // tuser: out_corner [1:0], frame_valid [2]
    output logic [2:0]              m_axis_tuser,
    output logic                    m_axis_tlast,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic r_renorm;
    logic w_push, w_pop, w_full, w_empty;
    t_job w_job_in, w_job_out;

    // config: single register at byte address 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RENORM && paddr[1:0] == 2'd0) ? {31'd0, r_renorm} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_renorm <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_RENORM && paddr[1:0] == 2'd0) begin
            r_renorm <= pwdata[0];
        end
    end

    // front: holds corners, forms edges and UV deltas
    tfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_corner (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_job    (w_job_in)
    );

    // queue decouples the two ends
    tfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_job_out)
    );

    // back: products, normalization, result requests
    tfr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_renorm (r_renorm),
        .i_empty  (w_empty),
        .i_job    (w_job_out),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_user   (m_axis_tuser),
        .o_last   (m_axis_tlast)
    );

endmodule

// ===== rtl/core/tfr_checker.sv =====
// Port-level checks on the triangle tangent frame core, bound to the top level.
// Depends on tfr_pkg and triangle_tangent_frame_core.
module tfr_props
    import tfr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic [2:0]              m_axis_tuser,
    input  logic                    m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[1:0] == CORNER_LAST)))
        else $error("tlast not on corner 2");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser[1:0] == CORNER_0
        |=> m_axis_tvalid && m_axis_tuser[1:0] == CORNER_1)
        else $error("corner 1 did not follow corner 0");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[OUT_W-1:OFF_TAN] == '0)
        else $error("frame not zero when invalid");

endmodule

bind triangle_tangent_frame_core tfr_props u_tfr_props (.*);
